// ===== src/button_encoder_report_events_macros.svh =====
// Assertion helpers used by btn_enc_dp.
`ifndef BUTTON_ENCODER_REPORT_EVENTS_MACROS_SVH
`define BUTTON_ENCODER_REPORT_EVENTS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BTN_ENC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BTN_ENC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/btn_enc_pkg.sv =====
package btn_enc_pkg;

    localparam int BTN_W      = 32;
    localparam int IDX_W      = 5;
    localparam int ENC_W      = 4;
    localparam int CNT_W      = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [CNT_W-1:0] HALF_BITS     = 6'd16;
    localparam logic [BTN_W-1:0] UNMAPPED_MASK = 32'h0000_0700;  // indices 8..10
    localparam logic [ENC_W-1:0] ENC_POS_MAX   = 4'hF;
    localparam logic [ENC_W-1:0] ENC_POS_MIN   = 4'h0;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_BTN = 1'b1;

    typedef enum logic [1:0] {
        POL_UNKNOWN = 2'd0,
        POL_HIGH    = 2'd1,
        POL_LOW     = 2'd2
    } pol_t;

    typedef struct packed {
        logic load;
        logic emit_enc;
        logic emit_btn;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic enc_pending;
        logic diff_any;
        logic diff_cur;
        logic last_btn;
        logic out_free;
    } ctrl_stat_t;

    function automatic logic [2:0] nibble_ones(input logic [3:0] n);
        logic [2:0] c;
        c = 3'(n[0]) + 3'(n[1]) + 3'(n[2]) + 3'(n[3]);
        return c;
    endfunction

    // Eight independent nibble counts, then a short chain of narrow adds.
    function automatic logic [CNT_W-1:0] count_ones(input logic [BTN_W-1:0] v);
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < BTN_W / 4; k++) begin
            sum = sum + CNT_W'(nibble_ones(v[k*4 +: 4]));
        end
        return sum;
    endfunction

endpackage

// ===== src/btn_enc_ctrl.sv =====
module btn_enc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  btn_enc_pkg::ctrl_stat_t stat,
    output btn_enc_pkg::ctrl_cmd_t  cmd
);
    import btn_enc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (!stat.enc_pending && !stat.diff_any) begin
                    state_next = ST_IDLE;
                end else if (stat.enc_pending) begin
                    if (stat.out_free) begin
                        cmd.emit_enc = 1'b1;
                        if (!stat.diff_any) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (stat.diff_cur) begin
                    if (stat.out_free) begin
                        cmd.emit_btn = 1'b1;
                        cmd.step     = 1'b1;
                        if (stat.last_btn) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/btn_enc_dp.sv =====
`include "button_encoder_report_events_macros.svh"

module btn_enc_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [btn_enc_pkg::IN_DATA_W-1:0]    s_tdata,
    input  btn_enc_pkg::ctrl_cmd_t               cmd,
    output btn_enc_pkg::ctrl_stat_t              stat,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [btn_enc_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [0:0]                           m_tuser,
    output logic                                 m_tlast
);
    import btn_enc_pkg::*;

    pol_t             pol_reg;
    logic [BTN_W-1:0] held_reg;
    logic             enc_seen_reg;
    logic [ENC_W-1:0] enc_last_reg;
    logic             enc_pending_reg;
    logic             enc_inc_reg;
    logic [BTN_W-1:0] diff_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             shift_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_active_reg;
    logic             out_shift_reg;
    logic             out_last_reg;

    logic [BTN_W-1:0] in_bits;
    logic [ENC_W-1:0] in_enc;
    pol_t             pol_first;
    pol_t             pol_eff;
    logic [BTN_W-1:0] down;
    logic             enc_inc;
    logic [BTN_W-1:0] diff_rest;
    logic             emit;

    assign in_bits = s_tdata[BTN_W-1:0];
    assign in_enc  = s_tdata[BTN_W +: ENC_W];

    assign pol_first = (count_ones(in_bits) > HALF_BITS) ? POL_LOW : POL_HIGH;
    assign pol_eff   = (pol_reg == POL_UNKNOWN) ? pol_first : pol_reg;
    assign down      = (pol_eff == POL_LOW) ? ~in_bits : in_bits;

    // wrap between 15 and 0 flips the plain compare
    assign enc_inc = ((enc_last_reg < in_enc)
                      || (enc_last_reg == ENC_POS_MAX && in_enc == ENC_POS_MIN))
                     && !(enc_last_reg == ENC_POS_MIN && in_enc == ENC_POS_MAX);

    assign diff_rest = diff_reg & ~(BTN_W'(1) << idx_reg);
    assign emit      = cmd.emit_enc | cmd.emit_btn;

    assign stat.enc_pending = enc_pending_reg;
    assign stat.diff_any    = (diff_reg != '0);
    assign stat.diff_cur    = diff_reg[idx_reg];
    assign stat.last_btn    = (diff_rest == '0);
    assign stat.out_free    = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pol_reg         <= POL_UNKNOWN;
            held_reg        <= '0;
            enc_seen_reg    <= 1'b0;
            enc_last_reg    <= '0;
            enc_pending_reg <= 1'b0;
            diff_reg        <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                pol_reg      <= pol_eff;
                held_reg     <= down;
                diff_reg     <= (down ^ held_reg) & ~UNMAPPED_MASK;
                idx_reg      <= '0;
                enc_seen_reg <= 1'b1;
                enc_last_reg <= in_enc;
                // first report only latches the position
                enc_pending_reg <= enc_seen_reg && (in_enc != enc_last_reg);
            end else begin
                if (cmd.emit_enc) begin
                    enc_pending_reg <= 1'b0;
                end
                if (cmd.emit_btn) begin
                    diff_reg <= diff_rest;
                end
                if (cmd.step) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            enc_inc_reg <= enc_inc;
            shift_reg   <= down[0];
        end
        if (emit) begin
            out_kind_reg  <= cmd.emit_btn ? KIND_BTN : KIND_ENC;
            out_idx_reg   <= cmd.emit_btn ? idx_reg : '0;
            out_active_reg <= cmd.emit_btn ? held_reg[idx_reg] : enc_inc_reg;
            out_shift_reg <= shift_reg;
            out_last_reg  <= cmd.emit_btn ? (diff_rest == '0) : (diff_reg == '0);
        end
    end

    // tdata: button_index[4:0], active[5], shift_held[6], zero pad[7]
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {1'b0, out_shift_reg, out_active_reg, out_idx_reg};
    assign m_tuser[0] = out_kind_reg;
    assign m_tlast    = out_last_reg;

    `BTN_ENC_ASSERT_NOW(a_emit_on_change, cmd.emit_btn, diff_reg[idx_reg], "button item without a change")
    `BTN_ENC_ASSERT_NOW(a_skip_unmapped, cmd.emit_btn, !(idx_reg == 5'd8 || idx_reg == 5'd9 || idx_reg == 5'd10), "unmapped index emitted")
    `BTN_ENC_ASSERT_NEXT(a_last_drains, emit && (cmd.emit_btn ? (diff_rest == '0) : (diff_reg == '0)), !enc_pending_reg && diff_reg == '0, "work left after last item")
    `BTN_ENC_ASSERT_NEXT(a_pol_known, cmd.load, pol_reg != POL_UNKNOWN, "polarity unset after report")
    `BTN_ENC_ASSERT_NOW(a_no_overwrite, emit, !out_valid_reg || m_tready, "output item overwritten")

endmodule

// ===== src/button_encoder_report_events.sv =====
// After a report is accepted and loaded, a pending encoder event is emitted first, then one
// button event per changed index, in index order; each event comes from the output register.
// The scan steps through button indices from 0 upward and ends at the last changed bit.
// Output stalls hold the scan. A new report is taken once the previous scan is done.
// Reset (aresetn low, synchronous): polarity unknown, pressed set clear, encoder not latched.
module button_encoder_report_events (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [btn_enc_pkg::IN_DATA_W-1:0]   s_tdata,   // button_bits[31:0], encoder_byte[39:32]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [btn_enc_pkg::OUT_DATA_W-1:0]  m_tdata,   // button_index[4:0], active[5], shift_held[6]
    output logic [0:0]                          m_tuser,   // event_kind[0]
    output logic                                m_tlast
);
    import btn_enc_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    btn_enc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    btn_enc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
